// ----- rtl/ckas_pkg.sv -----
// ----------------------------------------------------------------------------
// ckas_pkg: shared types, constants and BCD helpers
// Key codes, time field numbers, the transaction structs passed between the
// stages, and the per-field BCD range tables used by the clock setter.
// ----------------------------------------------------------------------------
package ckas_pkg;

  typedef enum logic [2:0] {
    CMD_ADD    = 3'd0,
    CMD_REDUCE = 3'd1,
    CMD_ALARM  = 3'd2,
    CMD_SET    = 3'd3,
    CMD_LOAD   = 3'd4
  } cmd_e;

  localparam int unsigned NumFields = 7;

  // Time field numbers as used by the RTC register map.
  localparam logic [2:0] FLD_SECOND  = 3'd0;
  localparam logic [2:0] FLD_MINUTE  = 3'd1;
  localparam logic [2:0] FLD_HOUR    = 3'd2;
  localparam logic [2:0] FLD_DAY     = 3'd3;
  localparam logic [2:0] FLD_MONTH   = 3'd4;
  localparam logic [2:0] FLD_WEEKDAY = 3'd5;
  localparam logic [2:0] FLD_YEAR    = 3'd6;

  localparam logic [7:0] RTC_BASE       = 8'h80;
  localparam logic [7:0] ALARM_HOUR_MAX = 8'h23;
  localparam logic [7:0] ALARM_MIN_MAX  = 8'h59;
  localparam logic [1:0] ALARM_HOUR     = 2'd1;
  localparam logic [1:0] ALARM_MINUTE   = 2'd2;
  localparam logic [1:0] ALARM_COMMIT   = 2'd3;

  typedef struct packed {
    logic [2:0] command;
    logic [2:0] load_field;
    logic [7:0] load_value;
  } item_t;

  typedef struct packed {
    logic       rtc_write;
    logic [7:0] rtc_address;
    logic [7:0] rtc_data;
    logic [2:0] edit_field;
    logic [1:0] alarm_step;
    logic       alarm_editing;
    logic [5:0] draft_hour;
    logic [6:0] draft_minute;
    logic [5:0] alarm_hour;
    logic [6:0] alarm_minute;
    logic       alarm_on;
  } result_t;

  // Lowest legal BCD value of a time field.
  function automatic logic [7:0] field_lo(input logic [2:0] f);
    logic [7:0] r;
    case (f)
      FLD_DAY, FLD_MONTH, FLD_WEEKDAY: r = 8'h01;
      default:                         r = 8'h00;
    endcase
    return r;
  endfunction

  // Highest legal BCD value of a time field.
  function automatic logic [7:0] field_hi(input logic [2:0] f);
    logic [7:0] r;
    case (f)
      FLD_SECOND, FLD_MINUTE: r = 8'h59;
      FLD_HOUR:               r = 8'h23;
      FLD_DAY:                r = 8'h31;
      FLD_MONTH:              r = 8'h12;
      FLD_WEEKDAY:            r = 8'h07;
      default:                r = 8'h99;
    endcase
    return r;
  endfunction

  // Edit position (1 year through 7 second) to time field number.
  function automatic logic [2:0] edit_slot(input logic [2:0] pos);
    logic [2:0] r;
    case (pos)
      3'd1:    r = FLD_YEAR;
      3'd2:    r = FLD_MONTH;
      3'd3:    r = FLD_DAY;
      3'd4:    r = FLD_WEEKDAY;
      3'd5:    r = FLD_HOUR;
      3'd6:    r = FLD_MINUTE;
      default: r = FLD_SECOND;
    endcase
    return r;
  endfunction

  // One BCD step up or down with wrap-around inside lo..hi.
  function automatic logic [7:0] bcd_step(input logic [7:0] v, input logic [7:0] lo,
                                          input logic [7:0] hi, input logic up);
    logic [7:0] r;
    if (up) begin
      if (v >= hi) begin
        r = lo;
      end else if (v[3:0] == 4'h9) begin
        r = {v[7:4] + 4'd1, 4'h0};
      end else begin
        r = v + 8'd1;
      end
    end else begin
      if (v <= lo || v > hi) begin
        r = hi;
      end else if (v[3:0] == 4'h0) begin
        r = {v[7:4] - 4'd1, 4'h9};
      end else begin
        r = v - 8'd1;
      end
    end
    return r;
  endfunction

endpackage

// ----- rtl/clock_time_and_alarm_setter.sv -----
// An accepted transaction waits in the input register until it can move into
// the result register, which drives the outputs. Throughput: one transaction
// per cycle while out_ready_i stays high; the input register frees up in the
// same cycle that the result register is loaded or drained.
// Reset (rst_ni low, asynchronous) clears all time fields and alarm values to
// zero, leaves both edit modes idle and empties both pipeline registers.
// ----------------------------------------------------------------------------
// clock_time_and_alarm_setter: BCD clock and alarm setting controller
// Takes key and RTC readback transactions and returns, for each one, the RTC
// write it causes plus a snapshot of the edit and alarm state.
// ----------------------------------------------------------------------------
module clock_time_and_alarm_setter (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] command_i,
  input  logic [2:0] load_field_i,
  input  logic [7:0] load_value_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       rtc_write_o,
  output logic [7:0] rtc_address_o,
  output logic [7:0] rtc_data_o,
  output logic [2:0] edit_field_o,
  output logic [1:0] alarm_step_o,
  output logic       alarm_editing_o,
  output logic [5:0] draft_hour_o,
  output logic [6:0] draft_minute_o,
  output logic [5:0] alarm_hour_o,
  output logic [6:0] alarm_minute_o,
  output logic       alarm_on_o
);

  ckas_pkg::item_t   item_in;
  ckas_pkg::item_t   item_q;
  ckas_pkg::result_t res_c;
  ckas_pkg::result_t res_q;
  logic              item_vld;
  logic              out_can_load;
  logic              go;

  assign item_in.command    = command_i;
  assign item_in.load_field = load_field_i;
  assign item_in.load_value = load_value_i;

  // A held transaction moves into the result register whenever that register
  // is empty or being drained in this cycle; the state updates at that edge,
  // so the next transaction already sees it.
  assign go = item_vld && out_can_load;

  ckas_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (item_in),
    .take_i     (go),
    .vld_o      (item_vld),
    .item_o     (item_q)
  );

  ckas_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (go),
    .item_i (item_q),
    .res_o  (res_c)
  );

  ckas_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (go),
    .res_i       (res_c),
    .can_load_o  (out_can_load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_q)
  );

  assign rtc_write_o     = res_q.rtc_write;
  assign rtc_address_o   = res_q.rtc_address;
  assign rtc_data_o      = res_q.rtc_data;
  assign edit_field_o    = res_q.edit_field;
  assign alarm_step_o    = res_q.alarm_step;
  assign alarm_editing_o = res_q.alarm_editing;
  assign draft_hour_o    = res_q.draft_hour;
  assign draft_minute_o  = res_q.draft_minute;
  assign alarm_hour_o    = res_q.alarm_hour;
  assign alarm_minute_o  = res_q.alarm_minute;
  assign alarm_on_o      = res_q.alarm_on;

  // A transaction that leaves the input register always lands as a result.
  a_go_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go |=> out_valid_o)
    else $error("processed transaction did not produce a result");

  // Without a write, the address and data hold their neutral values.
  a_idle_write_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !rtc_write_o) |-> (rtc_address_o == ckas_pkg::RTC_BASE
                                       && rtc_data_o == 8'h00))
    else $error("write fields set without an RTC write");

  // A write only happens while a time field is selected.
  a_write_needs_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && rtc_write_o) |-> (edit_field_o != 3'd0))
    else $error("RTC write outside time editing");

endmodule

// ----- rtl/ckas_in_stage.sv -----
// ----------------------------------------------------------------------------
// ckas_in_stage: input register
// Holds one incoming key or load transaction until the control stage takes it.
// ----------------------------------------------------------------------------
module ckas_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  ckas_pkg::item_t item_i,
  input  logic            take_i,
  output logic            vld_o,
  output ckas_pkg::item_t item_o
);

  logic            vld_q;
  logic            vld_d;
  ckas_pkg::item_t item_q;

  // The register frees up in the same cycle its content is taken.
  assign in_ready_o = !vld_q || take_i;
  assign vld_d      = (in_valid_i && in_ready_o) || (vld_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

// ----- rtl/ckas_ctrl.sv -----
// ----------------------------------------------------------------------------
// ckas_ctrl: time fields and edit mode machine
// Keeps the BCD time fields, the time and alarm edit state, and builds the
// result of one transaction in a single pass.
// ----------------------------------------------------------------------------
module ckas_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              go_i,
  input  ckas_pkg::item_t   item_i,
  output ckas_pkg::result_t res_o
);

  logic [7:0] fields_q [ckas_pkg::NumFields];
  logic [7:0] fields_d [ckas_pkg::NumFields];
  logic [2:0] fidx_q;
  logic [2:0] fidx_d;
  logic       ted_act_q, ted_act_d;
  logic       ted_ok_q, ted_ok_d;
  logic       aed_ok_q, aed_ok_d;
  logic       alm_act_q, alm_act_d;
  logic [1:0] aidx_q, aidx_d;
  logic [7:0] draft_hr_q, draft_hr_d, draft_mn_q, draft_mn_d;
  logic [7:0] save_hr_q, save_hr_d, save_mn_q, save_mn_d;
  logic       alm_flag_q, alm_flag_d;

  logic       k_add, k_red, k_alm, k_set, k_load;
  logic [3:0] fidx_w;
  logic [2:0] slot;
  logic       wr;
  logic [7:0] addr;
  logic [7:0] data;

  always_comb begin
    k_add  = 1'b0;
    k_red  = 1'b0;
    k_alm  = 1'b0;
    k_set  = 1'b0;
    k_load = 1'b0;
    case (ckas_pkg::cmd_e'(item_i.command))
      ckas_pkg::CMD_ADD:    k_add  = 1'b1;
      ckas_pkg::CMD_REDUCE: k_red  = 1'b1;
      ckas_pkg::CMD_ALARM:  k_alm  = 1'b1;
      ckas_pkg::CMD_SET:    k_set  = 1'b1;
      ckas_pkg::CMD_LOAD:   k_load = 1'b1;
      default:              k_load = 1'b0;
    endcase
  end

  always_comb begin
    fields_d   = fields_q;
    fidx_w     = {1'b0, fidx_q};
    ted_act_d  = ted_act_q;
    ted_ok_d   = ted_ok_q;
    aed_ok_d   = aed_ok_q;
    alm_act_d  = alm_act_q;
    aidx_d     = aidx_q;
    draft_hr_d = draft_hr_q;
    draft_mn_d = draft_mn_q;
    save_hr_d  = save_hr_q;
    save_mn_d  = save_mn_q;
    alm_flag_d = alm_flag_q;
    wr         = 1'b0;
    addr       = ckas_pkg::RTC_BASE;
    data       = 8'h00;
    slot       = ckas_pkg::edit_slot(fidx_q);

    if (go_i && k_load) begin
      for (int i = 0; i < ckas_pkg::NumFields; i++) begin
        if (item_i.load_field == 3'(i)) begin
          fields_d[i] = item_i.load_value;
        end
      end
    end else if (go_i) begin
      // Time editing: SET walks the fields, ADD and REDUCE step the selected one.
      if ((ted_act_q || k_set) && ted_ok_q) begin
        aed_ok_d = 1'b0;
        if (k_set) begin
          fidx_w = fidx_w + 4'd1;
        end
        ted_act_d = 1'b1;
        if (fidx_w[3]) begin
          fidx_w    = 4'd0;
          ted_act_d = 1'b0;
          aed_ok_d  = 1'b1;
        end
        slot = ckas_pkg::edit_slot(fidx_w[2:0]);
        if (fidx_w != 4'd0 && (k_add || k_red)) begin
          fields_d[slot] = ckas_pkg::bcd_step(fields_q[slot], ckas_pkg::field_lo(slot),
                                              ckas_pkg::field_hi(slot), k_add);
          wr   = 1'b1;
          addr = ckas_pkg::RTC_BASE | {4'b0000, slot, 1'b0};
          data = fields_d[slot];
        end
      end

      // Alarm editing: hour, then minute, then commit on the third SET.
      if ((alm_act_d || k_alm) && aed_ok_d) begin
        alm_act_d  = 1'b1;
        alm_flag_d = 1'b1;
        if (!ted_act_d) begin
          draft_hr_d = fields_d[ckas_pkg::FLD_HOUR];
          draft_mn_d = fields_d[ckas_pkg::FLD_MINUTE];
        end
        ted_ok_d  = 1'b0;
        ted_act_d = 1'b1;
        if (k_set) begin
          aidx_d = aidx_d + 2'd1;
        end
        if (aidx_d == ckas_pkg::ALARM_HOUR && (k_add || k_red)) begin
          draft_hr_d = ckas_pkg::bcd_step(draft_hr_d, 8'h00, ckas_pkg::ALARM_HOUR_MAX, k_add);
        end else if (aidx_d == ckas_pkg::ALARM_MINUTE && (k_add || k_red)) begin
          draft_mn_d = ckas_pkg::bcd_step(draft_mn_d, 8'h00, ckas_pkg::ALARM_MIN_MAX, k_add);
        end else if (aidx_d == ckas_pkg::ALARM_COMMIT) begin
          ted_ok_d  = 1'b1;
          alm_act_d = 1'b0;
          save_hr_d = draft_hr_d;
          save_mn_d = draft_mn_d;
          aidx_d    = 2'd0;
          ted_act_d = 1'b0;
        end
      end
    end
    fidx_d = fidx_w[2:0];
  end

  always_comb begin
    res_o.rtc_write     = wr;
    res_o.rtc_address   = addr;
    res_o.rtc_data      = data;
    res_o.edit_field    = fidx_d;
    res_o.alarm_step    = aidx_d;
    res_o.alarm_editing = alm_act_d;
    res_o.draft_hour    = draft_hr_d[5:0];
    res_o.draft_minute  = draft_mn_d[6:0];
    res_o.alarm_hour    = save_hr_d[5:0];
    res_o.alarm_minute  = save_mn_d[6:0];
    res_o.alarm_on      = alm_flag_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ckas_pkg::NumFields; i++) begin
        fields_q[i] <= 8'h00;
      end
      fidx_q     <= 3'd0;
      ted_act_q  <= 1'b0;
      ted_ok_q   <= 1'b1;
      aed_ok_q   <= 1'b1;
      alm_act_q  <= 1'b0;
      aidx_q     <= 2'd0;
      draft_hr_q <= 8'h00;
      draft_mn_q <= 8'h00;
      save_hr_q  <= 8'h00;
      save_mn_q  <= 8'h00;
      alm_flag_q <= 1'b0;
    end else if (go_i) begin
      fields_q   <= fields_d;
      fidx_q     <= fidx_d;
      ted_act_q  <= ted_act_d;
      ted_ok_q   <= ted_ok_d;
      aed_ok_q   <= aed_ok_d;
      alm_act_q  <= alm_act_d;
      aidx_q     <= aidx_d;
      draft_hr_q <= draft_hr_d;
      draft_mn_q <= draft_mn_d;
      save_hr_q  <= save_hr_d;
      save_mn_q  <= save_mn_d;
      alm_flag_q <= alm_flag_d;
    end
  end

  // The commit step is never left stored; it folds straight back to zero.
  a_no_commit_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    aidx_q != ckas_pkg::ALARM_COMMIT)
    else $error("alarm step register holds the commit code");

  // Time editing is locked out exactly while alarm editing runs.
  a_alarm_locks_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alm_act_q == !ted_ok_q)
    else $error("alarm mode and time edit lock disagree");

  // Alarm entry is blocked only while a time field is selected for editing.
  a_time_blocks_alarm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !aed_ok_q |-> (ted_act_q && fidx_q != 3'd0))
    else $error("alarm entry blocked outside time editing");

endmodule

// ----- rtl/ckas_out_stage.sv -----
// ----------------------------------------------------------------------------
// ckas_out_stage: result register
// Holds one result transaction until the consumer takes it.
// ----------------------------------------------------------------------------
module ckas_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  ckas_pkg::result_t res_i,
  output logic              can_load_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ckas_pkg::result_t res_o
);

  logic              vld_q;
  logic              vld_d;
  ckas_pkg::result_t res_q;

  assign can_load_o = !vld_q || out_ready_i;
  assign vld_d      = load_i || (vld_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = vld_q;
  assign res_o       = res_q;

endmodule
